FILE: design/lexer_token_dfa_assert.svh
// ----------------------------------------------------------------------------
// Lexer token DFA assertion macros
// Concurrent property wrappers clocked on aclk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef LEXER_TOKEN_DFA_ASSERT_SVH
`define LEXER_TOKEN_DFA_ASSERT_SVH

// check cons in the same cycle as ante
`define LTD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// check cons in the cycle after ante
`define LTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ltd_pkg.sv
// ----------------------------------------------------------------------------
// Lexer token DFA package
// Token kinds, error causes, scanner states, character codes and the result
// record shared by the scanner step logic and the top level.
// ----------------------------------------------------------------------------
package ltd_pkg;

    localparam int NUM_WIDTH_DEF  = 32;
    localparam int LINE_WIDTH_DEF = 16;

    localparam int LIMIT_W = 6;
    localparam logic [LIMIT_W-1:0] ID_LIMIT_RESET = 6'd20;

    localparam int KIND_W  = 5;
    localparam int ERR_W   = 3;
    localparam int VALUE_W = 32;
    localparam int LEN_W   = 8;
    localparam int LNUM_W  = 16;

    typedef enum logic [KIND_W-1:0] {
        TK_ID, TK_NUM, TK_RNUM, TK_PLUS, TK_MINUS, TK_MUL, TK_DIV, TK_LT, TK_LE,
        TK_DEF, TK_GT, TK_GE, TK_ENDDEF, TK_EQ, TK_NE, TK_ASSIGNOP, TK_COLON,
        TK_RANGEOP, TK_SEMICOL, TK_COMMA, TK_SQBO, TK_SQBC, TK_BO, TK_BC,
        TK_END, TK_ERROR
    } token_kind_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE, ERR_INVALID_CHAR, ERR_DOT_DIGIT, ERR_EXP_DIGIT, ERR_SIGN_DIGIT,
        ERR_EQ_EQ, ERR_BANG_EQ, ERR_DOT_DOT
    } err_code_t;

    typedef enum logic [4:0] {
        S_START, S_ID, S_NUM, S_NUMDOT, S_RFRAC, S_EXP, S_EXPSIGN, S_EXPDIG,
        S_STAR, S_COMM, S_COMMSTAR, S_LT, S_GT, S_EQ, S_BANG, S_COLON, S_DOT
    } scan_state_t;

    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_BANG       = 8'h21;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_SEMICOL    = 8'h3B;
    localparam logic [7:0] CH_LESS       = 8'h3C;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_GREATER    = 8'h3E;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_E    = 8'h45;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_LBRACKET   = 8'h5B;
    localparam logic [7:0] CH_RBRACKET   = 8'h5D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_E    = 8'h65;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;

    typedef struct packed {
        token_kind_t        kind;
        err_code_t          err;
        logic [VALUE_W-1:0] value;
        logic [LEN_W-1:0]   len;
        logic [LNUM_W-1:0]  line;
        logic               is_last;
    } result_t;

endpackage

FILE: design/lexer_token_dfa.sv
// An accepted transaction writes its results into the result queue register, and
// results leave from the queue head. Throughput: one input transaction per cycle
// while the four-entry queue has room for two results; two tokens leave one by one.
// The scanner transition is one pass of logic between the state and queue registers.
// Reset (aresetn low, synchronous): scanner to start, line counter to one,
// identifier limit to 20, result queue emptied.
// ----------------------------------------------------------------------------
// Lexer token DFA
// Byte-stream lexical scanner with a result queue on the master side.
// ----------------------------------------------------------------------------
module lexer_token_dfa
    import ltd_pkg::*;
#(
    parameter int NUM_WIDTH  = NUM_WIDTH_DEF,
    parameter int LINE_WIDTH = LINE_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [LIMIT_W-1:0] cfg_wr_data,   // max_identifier_length
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,       // [7:0] char_code
    input  logic [0:0]         s_tuser,       // [0] end_of_input
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [63:0]        m_tdata,       // [2:0] error_code, [34:3] num_value,
                                              // [42:35] lexeme_length,
                                              // [58:43] line_number, [63:59] zero
    output logic [KIND_W-1:0]  m_tuser,       // [4:0] token_kind
    output logic               m_tlast
);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    logic [LIMIT_W-1:0]    limit_reg;
    scan_state_t           state_reg, state_next;
    logic [LIMIT_W-1:0]    ident_reg, ident_next;
    logic [NUM_WIDTH-1:0]  acc_reg, acc_next;
    logic [LEN_W-1:0]      cnt_reg, cnt_next;
    logic [LINE_WIDTH-1:0] line_reg, line_next;

    result_t               res0;
    result_t               res1;
    logic [1:0]            res_count;

    result_t               queue_reg [QDEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]     fill_reg, fill_next;
    logic                  accept;
    logic                  pop;
    logic [1:0]            push_n;
    result_t               head;

    ltd_step #(
        .NUM_WIDTH  (NUM_WIDTH),
        .LINE_WIDTH (LINE_WIDTH)
    ) u_step (
        .ident_limit       (limit_reg),
        .char_code         (s_tdata),
        .end_of_input      (s_tuser[0]),
        .scan_state        (state_reg),
        .ident_length      (ident_reg),
        .number_accum      (acc_reg),
        .lexeme_count      (cnt_reg),
        .line_counter      (line_reg),
        .scan_state_next   (state_next),
        .ident_length_next (ident_next),
        .number_accum_next (acc_next),
        .lexeme_count_next (cnt_next),
        .line_counter_next (line_next),
        .res0              (res0),
        .res1              (res1),
        .res_count         (res_count)
    );

    assign s_tready  = (fill_reg <= QCNT_W'(QDEPTH - 2));
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = (fill_reg != '0);
    assign pop       = m_tvalid && m_tready;
    assign push_n    = accept ? res_count : 2'd0;
    assign fill_next = fill_reg + QCNT_W'(push_n) - QCNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= ID_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_START;
            ident_reg <= '0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            line_reg  <= LINE_WIDTH'(1);
        end else if (accept) begin
            state_reg <= state_next;
            ident_reg <= ident_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            line_reg  <= line_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push_n);
            rd_ptr_reg <= rd_ptr_reg + QPTR_W'(pop);
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (push_n == 2'd2) begin
            queue_reg[wr_ptr_reg + QPTR_W'(1)] <= res1;
        end
    end

    assign head    = queue_reg[rd_ptr_reg];
    assign m_tdata = {5'b00000, head.line, head.len, head.value, head.err};
    assign m_tuser = head.kind;
    assign m_tlast = head.is_last;

endmodule

FILE: design/ltd_step.sv
// ----------------------------------------------------------------------------
// Lexer token DFA step
// One scanner transition: from the current scanner state and one input byte
// (or end of input) form the next state and up to two tokens.
// ----------------------------------------------------------------------------
module ltd_step
    import ltd_pkg::*;
#(
    parameter int NUM_WIDTH  = NUM_WIDTH_DEF,
    parameter int LINE_WIDTH = LINE_WIDTH_DEF
) (
    input  logic [LIMIT_W-1:0]    ident_limit,
    input  logic [7:0]            char_code,
    input  logic                  end_of_input,
    input  scan_state_t           scan_state,
    input  logic [LIMIT_W-1:0]    ident_length,
    input  logic [NUM_WIDTH-1:0]  number_accum,
    input  logic [LEN_W-1:0]      lexeme_count,
    input  logic [LINE_WIDTH-1:0] line_counter,
    output scan_state_t           scan_state_next,
    output logic [LIMIT_W-1:0]    ident_length_next,
    output logic [NUM_WIDTH-1:0]  number_accum_next,
    output logic [LEN_W-1:0]      lexeme_count_next,
    output logic [LINE_WIDTH-1:0] line_counter_next,
    output result_t               res0,
    output result_t               res1,
    output logic [1:0]            res_count
);

    localparam int SUM_W = NUM_WIDTH + 4;

    logic                  c_letter;
    logic                  c_digit;
    logic                  c_blank;
    logic                  c_nl;
    logic [NUM_WIDTH-1:0]  digit_val;
    logic [SUM_W-1:0]      acc_sum;
    logic [NUM_WIDTH-1:0]  acc_add;
    logic [LEN_W-1:0]      cnt_up;
    logic [LINE_WIDTH-1:0] line_up;

    scan_state_t           st_state;
    logic [LIMIT_W-1:0]    st_ident;
    logic [NUM_WIDTH-1:0]  st_acc;
    logic                  st_emit;
    token_kind_t           st_kind;
    err_code_t             st_err;

    logic                  rescan;
    logic                  a_v;
    token_kind_t           a_kind;
    err_code_t             a_err;
    logic [NUM_WIDTH-1:0]  a_val;
    logic [LEN_W-1:0]      a_len;
    logic                  b_v;
    token_kind_t           b_kind;
    err_code_t             b_err;
    logic [LEN_W-1:0]      b_len;
    result_t               res_a;
    result_t               res_b;

    assign c_letter = ((char_code >= CH_LOWER_A) && (char_code <= CH_LOWER_Z)) ||
                      ((char_code >= CH_UPPER_A) && (char_code <= CH_UPPER_Z));
    assign c_digit  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign c_nl     = (char_code == CH_LF);
    assign c_blank  = (char_code == CH_SPACE) || (char_code == CH_TAB) ||
                      (char_code == CH_CR) || c_nl;

    assign digit_val = NUM_WIDTH'(char_code - CH_ZERO);
    assign acc_sum   = SUM_W'({number_accum, 3'b000}) + SUM_W'({number_accum, 1'b0}) +
                       SUM_W'(digit_val);
    assign acc_add   = (|acc_sum[SUM_W-1:NUM_WIDTH]) ? {NUM_WIDTH{1'b1}}
                                                     : acc_sum[NUM_WIDTH-1:0];
    assign cnt_up    = (&lexeme_count) ? lexeme_count : lexeme_count + LEN_W'(1);
    assign line_up   = (&line_counter) ? line_counter : line_counter + LINE_WIDTH'(1);

    // start-state scan of the byte
    always_comb begin
        st_state = S_START;
        st_ident = '0;
        st_acc   = '0;
        st_emit  = 1'b0;
        st_kind  = TK_ERROR;
        st_err   = ERR_NONE;
        if (c_letter) begin
            st_ident = LIMIT_W'(1);
            st_state = S_ID;
        end else if (c_digit) begin
            st_acc   = digit_val;
            st_state = S_NUM;
        end else if (!c_blank) begin
            case (char_code)
                CH_DOT:      st_state = S_DOT;
                CH_STAR:     st_state = S_STAR;
                CH_LESS:     st_state = S_LT;
                CH_GREATER:  st_state = S_GT;
                CH_EQUAL:    st_state = S_EQ;
                CH_BANG:     st_state = S_BANG;
                CH_COLON:    st_state = S_COLON;
                CH_SEMICOL:  begin st_emit = 1'b1; st_kind = TK_SEMICOL; end
                CH_COMMA:    begin st_emit = 1'b1; st_kind = TK_COMMA;   end
                CH_LBRACKET: begin st_emit = 1'b1; st_kind = TK_SQBO;    end
                CH_RBRACKET: begin st_emit = 1'b1; st_kind = TK_SQBC;    end
                CH_LPAREN:   begin st_emit = 1'b1; st_kind = TK_BO;      end
                CH_RPAREN:   begin st_emit = 1'b1; st_kind = TK_BC;      end
                CH_PLUS:     begin st_emit = 1'b1; st_kind = TK_PLUS;    end
                CH_MINUS:    begin st_emit = 1'b1; st_kind = TK_MINUS;   end
                CH_SLASH:    begin st_emit = 1'b1; st_kind = TK_DIV;     end
                default: begin
                    st_emit = 1'b1;
                    st_kind = TK_ERROR;
                    st_err  = ERR_INVALID_CHAR;
                end
            endcase
        end
    end

    // transition of the pending token
    always_comb begin
        scan_state_next   = scan_state;
        ident_length_next = ident_length;
        number_accum_next = number_accum;
        lexeme_count_next = lexeme_count;
        line_counter_next = line_counter;
        rescan = 1'b0;
        a_v    = 1'b0;
        a_kind = TK_ERROR;
        a_err  = ERR_NONE;
        a_val  = '0;
        a_len  = lexeme_count;
        b_v    = 1'b0;
        b_kind = TK_END;
        b_err  = ERR_NONE;
        b_len  = '0;
        if (end_of_input) begin
            a_v = 1'b1;
            case (scan_state)
                S_ID:      a_kind = TK_ID;
                S_NUM:     begin a_kind = TK_NUM; a_val = number_accum; end
                S_NUMDOT:  a_err = ERR_DOT_DIGIT;
                S_RFRAC,
                S_EXPDIG:  a_kind = TK_RNUM;
                S_EXP:     a_err = ERR_EXP_DIGIT;
                S_EXPSIGN: a_err = ERR_SIGN_DIGIT;
                S_STAR:    begin a_kind = TK_MUL;   a_len = LEN_W'(1); end
                S_LT:      begin a_kind = TK_LT;    a_len = LEN_W'(1); end
                S_GT:      begin a_kind = TK_GT;    a_len = LEN_W'(1); end
                S_EQ:      begin a_err = ERR_EQ_EQ;   a_len = LEN_W'(1); end
                S_BANG:    begin a_err = ERR_BANG_EQ; a_len = LEN_W'(1); end
                S_COLON:   begin a_kind = TK_COLON; a_len = LEN_W'(1); end
                S_DOT:     begin a_err = ERR_DOT_DOT; a_len = LEN_W'(1); end
                default:   a_v = 1'b0;
            endcase
            b_v               = 1'b1;
            scan_state_next   = S_START;
            ident_length_next = '0;
            number_accum_next = '0;
            lexeme_count_next = '0;
            line_counter_next = LINE_WIDTH'(1);
        end else begin
            case (scan_state)
                S_ID: begin
                    if ((c_letter || c_digit || (char_code == CH_UNDERSCORE)) &&
                        (ident_length < ident_limit)) begin
                        ident_length_next = ident_length + LIMIT_W'(1);
                        lexeme_count_next = cnt_up;
                    end else begin
                        a_v = 1'b1; a_kind = TK_ID; rescan = 1'b1;
                    end
                end
                S_NUM: begin
                    if (c_digit) begin
                        number_accum_next = acc_add;
                        lexeme_count_next = cnt_up;
                    end else if (char_code == CH_DOT) begin
                        lexeme_count_next = cnt_up;
                        scan_state_next   = S_NUMDOT;
                    end else begin
                        a_v = 1'b1; a_kind = TK_NUM; a_val = number_accum; rescan = 1'b1;
                    end
                end
                S_NUMDOT: begin
                    if (c_digit) begin
                        lexeme_count_next = cnt_up;
                        scan_state_next   = S_RFRAC;
                    end else if (char_code == CH_DOT) begin
                        a_v    = 1'b1;
                        a_kind = TK_NUM;
                        a_val  = number_accum;
                        a_len  = lexeme_count - LEN_W'(1);
                        b_v    = 1'b1;
                        b_kind = TK_RANGEOP;
                        b_len  = LEN_W'(2);
                        scan_state_next = S_START;
                    end else begin
                        a_v = 1'b1; a_err = ERR_DOT_DIGIT; rescan = 1'b1;
                    end
                end
                S_RFRAC: begin
                    if (c_digit) begin
                        lexeme_count_next = cnt_up;
                    end else if ((char_code == CH_UPPER_E) || (char_code == CH_LOWER_E)) begin
                        lexeme_count_next = cnt_up;
                        scan_state_next   = S_EXP;
                    end else begin
                        a_v = 1'b1; a_kind = TK_RNUM; rescan = 1'b1;
                    end
                end
                S_EXP: begin
                    if ((char_code == CH_PLUS) || (char_code == CH_MINUS)) begin
                        lexeme_count_next = cnt_up;
                        scan_state_next   = S_EXPSIGN;
                    end else if (c_digit) begin
                        lexeme_count_next = cnt_up;
                        scan_state_next   = S_EXPDIG;
                    end else begin
                        a_v = 1'b1; a_err = ERR_EXP_DIGIT; rescan = 1'b1;
                    end
                end
                S_EXPSIGN: begin
                    if (c_digit) begin
                        lexeme_count_next = cnt_up;
                        scan_state_next   = S_EXPDIG;
                    end else begin
                        a_v = 1'b1; a_err = ERR_SIGN_DIGIT; rescan = 1'b1;
                    end
                end
                S_EXPDIG: begin
                    if (c_digit) begin
                        lexeme_count_next = cnt_up;
                    end else begin
                        a_v = 1'b1; a_kind = TK_RNUM; rescan = 1'b1;
                    end
                end
                S_STAR: begin
                    if (char_code == CH_STAR) begin
                        scan_state_next = S_COMM;
                    end else begin
                        a_v = 1'b1; a_kind = TK_MUL; rescan = 1'b1;
                    end
                end
                S_COMM: begin
                    if (c_nl) line_counter_next = line_up;
                    if (char_code == CH_STAR) scan_state_next = S_COMMSTAR;
                end
                S_COMMSTAR: begin
                    if (c_nl) line_counter_next = line_up;
                    scan_state_next = (char_code == CH_STAR) ? S_START : S_COMM;
                end
                S_LT: begin
                    a_v = 1'b1;
                    if (char_code == CH_EQUAL) begin
                        a_kind = TK_LE; a_len = LEN_W'(2); scan_state_next = S_START;
                    end else if (char_code == CH_LESS) begin
                        a_kind = TK_DEF; a_len = LEN_W'(2); scan_state_next = S_START;
                    end else begin
                        a_kind = TK_LT; rescan = 1'b1;
                    end
                end
                S_GT: begin
                    a_v = 1'b1;
                    if (char_code == CH_EQUAL) begin
                        a_kind = TK_GE; a_len = LEN_W'(2); scan_state_next = S_START;
                    end else if (char_code == CH_GREATER) begin
                        a_kind = TK_ENDDEF; a_len = LEN_W'(2); scan_state_next = S_START;
                    end else begin
                        a_kind = TK_GT; rescan = 1'b1;
                    end
                end
                S_EQ: begin
                    a_v = 1'b1;
                    if (char_code == CH_EQUAL) begin
                        a_kind = TK_EQ; a_len = LEN_W'(2); scan_state_next = S_START;
                    end else begin
                        a_err = ERR_EQ_EQ; rescan = 1'b1;
                    end
                end
                S_BANG: begin
                    a_v = 1'b1;
                    if (char_code == CH_EQUAL) begin
                        a_kind = TK_NE; a_len = LEN_W'(2); scan_state_next = S_START;
                    end else begin
                        a_err = ERR_BANG_EQ; rescan = 1'b1;
                    end
                end
                S_COLON: begin
                    a_v = 1'b1;
                    if (char_code == CH_EQUAL) begin
                        a_kind = TK_ASSIGNOP; a_len = LEN_W'(2); scan_state_next = S_START;
                    end else begin
                        a_kind = TK_COLON; rescan = 1'b1;
                    end
                end
                S_DOT: begin
                    a_v = 1'b1;
                    if (char_code == CH_DOT) begin
                        a_kind = TK_RANGEOP; a_len = LEN_W'(2); scan_state_next = S_START;
                    end else begin
                        a_err = ERR_DOT_DOT; rescan = 1'b1;
                    end
                end
                default: rescan = 1'b1;
            endcase
            if (rescan) begin
                scan_state_next   = st_state;
                ident_length_next = st_ident;
                number_accum_next = st_acc;
                lexeme_count_next = LEN_W'(1);
                if (c_nl) line_counter_next = line_up;
                b_v    = st_emit;
                b_kind = st_kind;
                b_err  = st_err;
                b_len  = LEN_W'(1);
            end
        end
    end

    // pack and compact the two slots
    always_comb begin
        res_a.kind    = a_kind;
        res_a.err     = a_err;
        res_a.value   = VALUE_W'(a_val);
        res_a.len     = a_len;
        res_a.line    = LNUM_W'(line_counter);
        res_a.is_last = !b_v;
        res_b.kind    = b_kind;
        res_b.err     = b_err;
        res_b.value   = '0;
        res_b.len     = b_len;
        res_b.line    = LNUM_W'(line_counter);
        res_b.is_last = 1'b1;
        res0      = a_v ? res_a : res_b;
        res1      = res_b;
        res_count = 2'(a_v) + 2'(b_v);
    end

endmodule

FILE: design/ltd_checker.sv
// ----------------------------------------------------------------------------
// Lexer token DFA checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "lexer_token_dfa_assert.svh"

module ltd_checker
    import ltd_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [63:0]       m_tdata,
    input logic [KIND_W-1:0] m_tuser,
    input logic              m_tlast
);

    `LTD_ASSERT_NEXT(a_stall_holds_valid, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `LTD_ASSERT_NEXT(a_stall_holds_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")
    `LTD_ASSERT_SAME(a_error_code_match, m_tvalid, (m_tuser == TK_ERROR) == (m_tdata[2:0] != ERR_NONE), "error code does not match token kind")
    `LTD_ASSERT_SAME(a_end_is_last, m_tvalid && (m_tuser == TK_END), m_tlast && (m_tdata[42:35] == 8'd0), "END transaction not last or has a lexeme")

endmodule

bind lexer_token_dfa ltd_checker u_ltd_checker (.*);
